>>> sv/flash_tag_stream_deframer_defines.svh
// assertion macros used by the deframer parser module
`ifndef FLASH_TAG_STREAM_DEFRAMER_DEFINES_SVH
`define FLASH_TAG_STREAM_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FTS_ASSERT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, disabled during reset
`define FTS_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

>>> sv/fts_pkg.sv
// types, constants and helper functions for the flash tag stream deframer
`default_nettype none

package fts_pkg;

    // widest long tag length kept, in bits
    localparam int unsigned LEN_BITS = 32;
    localparam logic [31:0] LEN_LIMIT = 32'((64'd1 << LEN_BITS) - 64'd1);

    localparam int unsigned BCNT_W   = 4;
    localparam int unsigned TDATA_W  = 72;

    // signature characters
    localparam logic [7:0] CHR_F = 8'h46;
    localparam logic [7:0] CHR_C = 8'h43;
    localparam logic [7:0] CHR_W = 8'h57;
    localparam logic [7:0] CHR_S = 8'h53;

    // short length field value that escapes to a 32-bit length
    localparam logic [5:0] LEN_ESCAPE = 6'h3f;

    // tag ids with a media class
    localparam logic [9:0] TAG_VIDEO_STREAM = 10'd60;
    localparam logic [9:0] TAG_SOUND_HEAD   = 10'd18;
    localparam logic [9:0] TAG_SOUND_HEAD2  = 10'd45;
    localparam logic [9:0] TAG_VIDEO_FRAME  = 10'd61;
    localparam logic [9:0] TAG_SOUND_BLOCK  = 10'd19;
    localparam logic [9:0] TAG_JPEG         = 10'd21;

    // signature counter end and frame-rate section end
    localparam logic [BCNT_W-1:0] SIG_LAST_CNT  = 4'd7;
    localparam logic [BCNT_W-1:0] RATE_LAST_CNT = 4'd3;

    typedef enum logic [2:0] {
        PH_SIG   = 3'd0,
        PH_RECT0 = 3'd1,
        PH_RECTS = 3'd2,
        PH_RATE  = 3'd3,
        PH_TAGH0 = 3'd4,
        PH_TAGH1 = 3'd5,
        PH_LEN32 = 3'd6,
        PH_PAY   = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FILE_HDR = 2'd0,
        KIND_TAG_HDR  = 2'd1,
        KIND_TAG_PAY  = 2'd2,
        KIND_DISCARD  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_COMPRESSED = 2'd1,
        ERR_BAD_SIG    = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        CLS_OTHER        = 3'd0,
        CLS_VIDEO_STREAM = 3'd1,
        CLS_AUDIO_HEAD   = 3'd2,
        CLS_VIDEO_FRAME  = 3'd3,
        CLS_AUDIO_BLOCK  = 3'd4,
        CLS_JPEG         = 3'd5
    } class_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [9:0]  tag_id;
        class_t      tag_class;
        logic [31:0] tag_length;
        logic        tag_last;
        logic        header_done;
        logic [15:0] fps_8p8;
        err_t        error_code;
    } fts_result_t;

    function automatic class_t tag_class_of(input logic [9:0] id);
        class_t cls;
        case (id)
            TAG_VIDEO_STREAM: cls = CLS_VIDEO_STREAM;
            TAG_SOUND_HEAD:   cls = CLS_AUDIO_HEAD;
            TAG_SOUND_HEAD2:  cls = CLS_AUDIO_HEAD;
            TAG_VIDEO_FRAME:  cls = CLS_VIDEO_FRAME;
            TAG_SOUND_BLOCK:  cls = CLS_AUDIO_BLOCK;
            TAG_JPEG:         cls = CLS_JPEG;
            default:          cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

>>> sv/fts_parser.sv
// parse state machine: file header, tag headers and payload, one byte per step
`default_nettype none
`include "flash_tag_stream_deframer_defines.svh"

module fts_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          data_in,
    input  wire logic                file_start,
    output fts_pkg::fts_result_t     res
);
    import fts_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [BCNT_W-1:0]      byte_counter_reg, byte_counter_next;
    logic [4:0]             rect_skip_left_reg, rect_skip_left_next;
    logic                   first_is_c_reg, first_is_c_next;
    logic                   signature_bad_reg, signature_bad_next;
    logic [7:0]             header_low_byte_reg, header_low_byte_next;
    logic [9:0]             current_tag_reg, current_tag_next;
    logic [31:0]            current_length_reg, current_length_next;
    logic [31:0]            payload_left_reg, payload_left_next;
    logic [15:0]            rate_value_reg, rate_value_next;
    err_t                   error_state_reg, error_state_next;

    // state seen by this byte (file_start restarts before parsing)
    phase_t                 cur_phase;
    logic [BCNT_W-1:0]      cur_cnt;
    logic [4:0]             cur_rsl;
    logic                   cur_first_c;
    logic                   cur_sig_bad;
    logic [7:0]             cur_hlb;
    logic [9:0]             cur_tag;
    logic [31:0]            cur_len;
    logic [31:0]            cur_pl;
    logic [15:0]            cur_rate;
    err_t                   cur_err;

    logic [4:0]             nbits;
    logic [5:0]             rect_skip;
    logic [4:0]             rsl_dec;
    logic [5:0]             short_len;
    logic [9:0]             hdr_id;
    logic [31:0]            len_gather;
    logic [31:0]            len_sat;
    logic [31:0]            pl_dec;
    logic                   sig_bad_now;

    kind_t                  kind;
    logic                   last;
    logic                   tagfields;
    logic                   done;

    always_comb
    begin
        if (file_start)
        begin
            cur_phase   = PH_SIG;
            cur_cnt     = '0;
            cur_rsl     = '0;
            cur_first_c = 1'b0;
            cur_sig_bad = 1'b0;
            cur_hlb     = '0;
            cur_tag     = '0;
            cur_len     = '0;
            cur_pl      = '0;
            cur_rate    = '0;
            cur_err     = ERR_NONE;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_cnt     = byte_counter_reg;
            cur_rsl     = rect_skip_left_reg;
            cur_first_c = first_is_c_reg;
            cur_sig_bad = signature_bad_reg;
            cur_hlb     = header_low_byte_reg;
            cur_tag     = current_tag_reg;
            cur_len     = current_length_reg;
            cur_pl      = payload_left_reg;
            cur_rate    = rate_value_reg;
            cur_err     = error_state_reg;
        end
    end

    // (4*nbits-3+7)/8 rectangle bytes follow the first one
    assign nbits     = data_in[7:3];
    assign rect_skip = ({1'b0, nbits} + 6'd1) >> 1;
    assign rsl_dec   = cur_rsl - 5'd1;
    assign short_len = cur_hlb[5:0];
    assign hdr_id    = {data_in, cur_hlb[7:6]};
    assign pl_dec    = cur_pl - 32'd1;
    assign sig_bad_now = cur_sig_bad | (data_in != CHR_S);

    always_comb
    begin
        case (cur_cnt[1:0])
            2'd0:    len_gather = cur_len | {24'd0, data_in};
            2'd1:    len_gather = cur_len | {16'd0, data_in, 8'd0};
            2'd2:    len_gather = cur_len | {8'd0, data_in, 16'd0};
            default: len_gather = cur_len | {data_in, 24'd0};
        endcase
        len_sat = (len_gather > LEN_LIMIT) ? LEN_LIMIT : len_gather;
    end

    // next phase
    always_comb
    begin
        phase_next = cur_phase;
        if (cur_err == ERR_NONE)
        begin
            case (cur_phase)
                PH_SIG:
                begin
                    if (cur_cnt >= SIG_LAST_CNT)
                        phase_next = PH_RECT0;
                end
                PH_RECT0:
                begin
                    phase_next = (rect_skip == 6'd0) ? PH_RATE : PH_RECTS;
                end
                PH_RECTS:
                begin
                    if (rsl_dec == 5'd0)
                        phase_next = PH_RATE;
                end
                PH_RATE:
                begin
                    if (cur_cnt >= RATE_LAST_CNT)
                        phase_next = PH_TAGH0;
                end
                PH_TAGH0:
                begin
                    phase_next = PH_TAGH1;
                end
                PH_TAGH1:
                begin
                    if (short_len == LEN_ESCAPE)
                        phase_next = PH_LEN32;
                    else if (short_len == 6'd0)
                        phase_next = PH_TAGH0;
                    else
                        phase_next = PH_PAY;
                end
                PH_LEN32:
                begin
                    if (cur_cnt[1:0] == 2'd3)
                        phase_next = (len_sat == 32'd0) ? PH_TAGH0 : PH_PAY;
                end
                PH_PAY:
                begin
                    if (pl_dec == 32'd0)
                        phase_next = PH_TAGH0;
                end
                default:
                begin
                    phase_next = cur_phase;
                end
            endcase
        end
    end

    // datapath state
    always_comb
    begin
        byte_counter_next    = cur_cnt;
        rect_skip_left_next  = cur_rsl;
        first_is_c_next      = cur_first_c;
        signature_bad_next   = cur_sig_bad;
        header_low_byte_next = cur_hlb;
        current_tag_next     = cur_tag;
        current_length_next  = cur_len;
        payload_left_next    = cur_pl;
        rate_value_next      = cur_rate;
        error_state_next     = cur_err;
        if (cur_err == ERR_NONE)
        begin
            case (cur_phase)
                PH_SIG:
                begin
                    case (cur_cnt)
                        4'd0:
                        begin
                            if (data_in == CHR_C)
                                first_is_c_next = 1'b1;
                            else if (data_in != CHR_F)
                                signature_bad_next = 1'b1;
                        end
                        4'd1:
                        begin
                            if (data_in != CHR_W)
                                signature_bad_next = 1'b1;
                        end
                        4'd2:
                        begin
                            signature_bad_next = sig_bad_now;
                            if (sig_bad_now)
                                error_state_next = ERR_BAD_SIG;
                            else if (cur_first_c)
                                error_state_next = ERR_COMPRESSED;
                        end
                        default:
                        begin
                            signature_bad_next = cur_sig_bad;
                        end
                    endcase
                    if (cur_cnt >= SIG_LAST_CNT)
                        byte_counter_next = '0;
                    else
                        byte_counter_next = cur_cnt + 4'd1;
                end
                PH_RECT0:
                begin
                    rect_skip_left_next = rect_skip[4:0];
                    byte_counter_next   = '0;
                end
                PH_RECTS:
                begin
                    rect_skip_left_next = rsl_dec;
                    if (rsl_dec == 5'd0)
                        byte_counter_next = '0;
                end
                PH_RATE:
                begin
                    if (cur_cnt == 4'd0)
                        rate_value_next = {cur_rate[15:8], data_in};
                    else if (cur_cnt == 4'd1)
                        rate_value_next = {data_in, cur_rate[7:0]};
                    if (cur_cnt >= RATE_LAST_CNT)
                        byte_counter_next = '0;
                    else
                        byte_counter_next = cur_cnt + 4'd1;
                end
                PH_TAGH0:
                begin
                    header_low_byte_next = data_in;
                    current_tag_next     = '0;
                    current_length_next  = '0;
                    payload_left_next    = '0;
                end
                PH_TAGH1:
                begin
                    current_tag_next = hdr_id;
                    if (short_len == LEN_ESCAPE)
                    begin
                        current_length_next = '0;
                        byte_counter_next   = '0;
                    end
                    else
                    begin
                        current_length_next = {26'd0, short_len};
                        payload_left_next   = {26'd0, short_len};
                    end
                end
                PH_LEN32:
                begin
                    if (cur_cnt[1:0] == 2'd3)
                    begin
                        current_length_next = len_sat;
                        payload_left_next   = len_sat;
                        byte_counter_next   = '0;
                    end
                    else
                    begin
                        current_length_next = len_gather;
                        byte_counter_next   = cur_cnt + 4'd1;
                    end
                end
                PH_PAY:
                begin
                    payload_left_next = pl_dec;
                end
                default:
                begin
                    payload_left_next = cur_pl;
                end
            endcase
        end
    end

    // per-byte outputs
    always_comb
    begin
        kind      = KIND_FILE_HDR;
        last      = 1'b0;
        tagfields = 1'b0;
        if (cur_err != ERR_NONE)
        begin
            kind = KIND_DISCARD;
        end
        else
        begin
            case (cur_phase)
                PH_SIG, PH_RECT0, PH_RECTS, PH_RATE:
                begin
                    kind = KIND_FILE_HDR;
                end
                PH_TAGH0:
                begin
                    kind      = KIND_TAG_HDR;
                    tagfields = 1'b1;
                end
                PH_TAGH1:
                begin
                    kind      = KIND_TAG_HDR;
                    tagfields = 1'b1;
                    last      = (short_len == 6'd0);
                end
                PH_LEN32:
                begin
                    kind      = KIND_TAG_HDR;
                    tagfields = 1'b1;
                    last      = (cur_cnt[1:0] == 2'd3) && (len_sat == 32'd0);
                end
                PH_PAY:
                begin
                    kind      = KIND_TAG_PAY;
                    tagfields = 1'b1;
                    last      = (pl_dec == 32'd0);
                end
                default:
                begin
                    kind = KIND_FILE_HDR;
                end
            endcase
        end
        done = (cur_err == ERR_NONE) && (error_state_next == ERR_NONE)
            && (phase_next inside {PH_TAGH0, PH_TAGH1, PH_LEN32, PH_PAY});
    end

    always_comb
    begin
        res.kind        = kind;
        res.data        = data_in;
        res.tag_id      = tagfields ? current_tag_next : 10'd0;
        res.tag_class   = tagfields ? tag_class_of(current_tag_next) : CLS_OTHER;
        res.tag_length  = tagfields ? current_length_next : 32'd0;
        res.tag_last    = last;
        res.header_done = done;
        res.fps_8p8     = rate_value_next;
        res.error_code  = error_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_SIG;
            byte_counter_reg    <= '0;
            rect_skip_left_reg  <= '0;
            first_is_c_reg      <= 1'b0;
            signature_bad_reg   <= 1'b0;
            header_low_byte_reg <= '0;
            current_tag_reg     <= '0;
            current_length_reg  <= '0;
            payload_left_reg    <= '0;
            rate_value_reg      <= '0;
            error_state_reg     <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            byte_counter_reg    <= byte_counter_next;
            rect_skip_left_reg  <= rect_skip_left_next;
            first_is_c_reg      <= first_is_c_next;
            signature_bad_reg   <= signature_bad_next;
            header_low_byte_reg <= header_low_byte_next;
            current_tag_reg     <= current_tag_next;
            current_length_reg  <= current_length_next;
            payload_left_reg    <= payload_left_next;
            rate_value_reg      <= rate_value_next;
            error_state_reg     <= error_state_next;
        end
    end

    `FTS_ASSERT(a_err_parks_in_sig, clk, rst_n, error_state_reg != ERR_NONE, phase_reg == PH_SIG)
    `FTS_ASSERT(a_pay_left_nonzero, clk, rst_n, phase_reg == PH_PAY, payload_left_reg != '0)
    `FTS_ASSERT(a_rect_left_nonzero, clk, rst_n, phase_reg == PH_RECTS, rect_skip_left_reg != '0)
    `FTS_ASSERT_NEXT(a_last_to_tag_hdr, clk, rst_n, step && res.tag_last, phase_reg == PH_TAGH0)

endmodule

`default_nettype wire

>>> sv/flash_tag_stream_deframer.sv
// top level of the flash tag stream deframer, input beat register, parser, output beat register
// an accepted beat is held in the input beat register, then parsed into the output beat register when the output moves
// throughput: one byte per cycle; a new beat is taken every cycle the output moves
// the rate is set by the single parse state machine, updated once per byte
// reset: rst_n asynchronous active low, clears both beat valid flags and all parse state
// a beat with file_start set restarts the parse before that byte is examined
`default_nettype none

module flash_tag_stream_deframer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input byte stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // data_in
    input  wire logic                          s_axis_tuser,  // file_start
    // deframed byte stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // data_out, tag_id, tag_class, tag_length, header_done, fps_8p8, error_code
    output logic [fts_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic [1:0]                         m_axis_tuser,  // byte_kind
    output logic                               m_axis_tlast   // tag_last
);
    import fts_pkg::*;

    // input beat register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_data_reg;
    logic        in_start_reg;

    // output beat register
    logic        out_valid_reg, out_valid_next;
    fts_result_t out_res_reg;

    fts_result_t res;
    logic        advance;
    logic        step;

    // output register frees up when empty or being taken downstream
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg;
    end

    // parse state machine, evaluates the held beat against current state
    fts_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_in    (in_data_reg),
        .file_start (in_start_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (step)
            out_res_reg <= res;
    end

    // pack result fields, data in the lowest bits and error_code in the highest
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.error_code,
                            out_res_reg.fps_8p8,
                            out_res_reg.header_done,
                            out_res_reg.tag_length,
                            out_res_reg.tag_class,
                            out_res_reg.tag_id,
                            out_res_reg.data};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.tag_last;

endmodule

`default_nettype wire

>>> verif/flash_tag_stream_deframer_tb.sv
// self-checking testbench for the flash tag stream deframer
`timescale 1ns / 1ps

module flash_tag_stream_deframer_tb;
    import fts_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_in
    logic        s_axis_tuser;   // file_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // data_out, tag_id, tag_class, tag_length, header_done, fps_8p8, error_code
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;   // byte_kind
    logic        m_axis_tlast;   // tag_last

    flash_tag_stream_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // idling odds in percent, per cycle
    int src_idle_pct;
    int sink_stall_pct;
    int fail_count;

    // expected output beats, oldest first
    fts_result_t pending_bytes[$];

    // parser state mirrored by the predictor
    phase_t      pstate;
    logic [3:0]  cnt;
    logic [4:0]  rect_remaining;
    logic        lead_c;
    logic        sig_wrong;
    logic [7:0]  hdr_low;
    logic [9:0]  cur_id;
    logic [31:0] cur_len;
    logic [31:0] pay_remaining;
    logic [15:0] rate_reg;
    err_t        err_reg;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("flash_tag_stream_deframer_tb failed");
        $finish;
    end

    task automatic reset_parse_model();
        pstate         = PH_SIG;
        cnt            = '0;
        rect_remaining = '0;
        lead_c         = 1'b0;
        sig_wrong      = 1'b0;
        hdr_low        = '0;
        cur_id         = '0;
        cur_len        = '0;
        pay_remaining  = '0;
        rate_reg       = '0;
        err_reg        = ERR_NONE;
    endtask

    // works out the output beat for one accepted byte and advances the parse
    task automatic deframe_byte(input logic [7:0] b, input logic start,
                                output fts_result_t r);
        logic        tag_fields;
        logic [15:0] hdr;
        logic [5:0]  short_len;
        int          skip;
        tag_fields = 1'b0;
        r = '0;
        r.data = b;
        if (start)
            reset_parse_model();
        if (err_reg != ERR_NONE)
            r.kind = KIND_DISCARD;
        else
        begin
            case (pstate)
                PH_SIG:
                begin
                    r.kind = KIND_FILE_HDR;
                    if (cnt == 4'd0)
                    begin
                        if (b == CHR_C)
                            lead_c = 1'b1;
                        else if (b != CHR_F)
                            sig_wrong = 1'b1;
                    end
                    else if (cnt == 4'd1)
                    begin
                        if (b != CHR_W)
                            sig_wrong = 1'b1;
                    end
                    else if (cnt == 4'd2)
                    begin
                        if (b != CHR_S)
                            sig_wrong = 1'b1;
                        if (sig_wrong)
                            err_reg = ERR_BAD_SIG;
                        else if (lead_c)
                            err_reg = ERR_COMPRESSED;
                    end
                    if (cnt >= SIG_LAST_CNT)
                    begin
                        cnt    = '0;
                        pstate = PH_RECT0;
                    end
                    else
                        cnt = cnt + 4'd1;
                end
                PH_RECT0:
                begin
                    // nbits in the top five bits, four fields of nbits after them
                    r.kind         = KIND_FILE_HDR;
                    skip           = (4 * int'(b[7:3]) + 4) / 8;
                    rect_remaining = skip[4:0];
                    cnt            = '0;
                    pstate         = (skip == 0) ? PH_RATE : PH_RECTS;
                end
                PH_RECTS:
                begin
                    r.kind         = KIND_FILE_HDR;
                    rect_remaining = rect_remaining - 5'd1;
                    if (rect_remaining == 5'd0)
                    begin
                        cnt    = '0;
                        pstate = PH_RATE;
                    end
                end
                PH_RATE:
                begin
                    r.kind = KIND_FILE_HDR;
                    if (cnt == 4'd0)
                        rate_reg[7:0] = b;
                    else if (cnt == 4'd1)
                        rate_reg[15:8] = b;
                    if (cnt >= RATE_LAST_CNT)
                    begin
                        cnt    = '0;
                        pstate = PH_TAGH0;
                    end
                    else
                        cnt = cnt + 4'd1;
                end
                PH_TAGH0:
                begin
                    r.kind        = KIND_TAG_HDR;
                    tag_fields    = 1'b1;
                    hdr_low       = b;
                    cur_id        = '0;
                    cur_len       = '0;
                    pay_remaining = '0;
                    pstate        = PH_TAGH1;
                end
                PH_TAGH1:
                begin
                    r.kind     = KIND_TAG_HDR;
                    tag_fields = 1'b1;
                    hdr        = {b, hdr_low};
                    short_len  = hdr[5:0];
                    cur_id     = hdr[15:6];
                    if (short_len == LEN_ESCAPE)
                    begin
                        cur_len = '0;
                        cnt     = '0;
                        pstate  = PH_LEN32;
                    end
                    else
                    begin
                        cur_len       = 32'(short_len);
                        pay_remaining = 32'(short_len);
                        if (short_len == 6'd0)
                        begin
                            r.tag_last = 1'b1;
                            pstate     = PH_TAGH0;
                        end
                        else
                            pstate = PH_PAY;
                    end
                end
                PH_LEN32:
                begin
                    r.kind     = KIND_TAG_HDR;
                    tag_fields = 1'b1;
                    cur_len    = cur_len | (32'(b) << {cnt[1:0], 3'b000});
                    if (cnt[1:0] == 2'd3)
                    begin
                        if (cur_len > LEN_LIMIT)
                            cur_len = LEN_LIMIT;
                        pay_remaining = cur_len;
                        cnt           = '0;
                        if (cur_len == 32'd0)
                        begin
                            r.tag_last = 1'b1;
                            pstate     = PH_TAGH0;
                        end
                        else
                            pstate = PH_PAY;
                    end
                    else
                        cnt = cnt + 4'd1;
                end
                default:
                begin
                    r.kind        = KIND_TAG_PAY;
                    tag_fields    = 1'b1;
                    pay_remaining = pay_remaining - 32'd1;
                    if (pay_remaining == 32'd0)
                    begin
                        r.tag_last = 1'b1;
                        pstate     = PH_TAGH0;
                    end
                end
            endcase
        end
        if (tag_fields)
        begin
            r.tag_id     = cur_id;
            r.tag_length = cur_len;
            case (cur_id)
                TAG_VIDEO_STREAM:              r.tag_class = CLS_VIDEO_STREAM;
                TAG_SOUND_HEAD, TAG_SOUND_HEAD2: r.tag_class = CLS_AUDIO_HEAD;
                TAG_VIDEO_FRAME:               r.tag_class = CLS_VIDEO_FRAME;
                TAG_SOUND_BLOCK:               r.tag_class = CLS_AUDIO_BLOCK;
                TAG_JPEG:                      r.tag_class = CLS_JPEG;
                default:                       r.tag_class = CLS_OTHER;
            endcase
        end
        r.header_done = (err_reg == ERR_NONE) && (pstate >= PH_TAGH0);
        r.fps_8p8     = rate_reg;
        r.error_code  = err_reg;
    endtask

    // drive one byte, wait for the handshake, then queue its expected beat
    task automatic send_byte(input logic [7:0] b, input logic start);
        fts_result_t want;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        deframe_byte(b, start, want);
        pending_bytes.push_back(want);
    endtask

    task automatic send_file(input logic [7:0] fb[$]);
        foreach (fb[i])
            send_byte(fb[i], i == 0);
    endtask

    // shortest header, end tag, escaped zero length, escaped maximum length
    task automatic test_well_formed_file();
        logic [7:0] fb[$];
        fb = {CHR_F, CHR_W, CHR_S, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h07,                            // nbits zero, no rectangle bytes
              8'h80, 8'hff, 8'h00, 8'h00,       // rate then frame count
              8'h00, 8'h00,                     // end tag, no payload
              8'h3f, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00,  // id 60, long length zero
              8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,  // id 1023, all-ones length
              8'h00};                           // first payload byte, cut short
        send_file(fb);
    endtask

    // compressed signature with a discarded byte, then a bad third byte
    task automatic test_signature_errors();
        logic [7:0] fb[$];
        fb = {CHR_C, CHR_W, CHR_S, 8'h5a};
        send_file(fb);
        fb = {CHR_F, CHR_W, 8'h00};
        send_file(fb);
    endtask

    // random files, mostly well formed, with noise and truncation
    task automatic test_random_phase(input int src_pct, input int sink_pct,
                                     input int target);
        logic [7:0]  fb[$];
        logic [7:0]  sig[3];
        logic [9:0]  class_ids[7];
        logic [9:0]  id;
        logic [31:0] lenv;
        logic        cut_short;
        int          sent, pick, nbits, nskip, ntags, cut, n;
        class_ids = '{TAG_VIDEO_STREAM, TAG_SOUND_HEAD, TAG_SOUND_HEAD2, TAG_VIDEO_FRAME,
                      TAG_SOUND_BLOCK, TAG_JPEG, 10'd0};
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < target)
        begin
            fb   = {};
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                // loose bytes, file_start now and then
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom), $urandom_range(0, 9) == 0);
                sent += n;
                continue;
            end
            sig = '{CHR_F, CHR_W, CHR_S};
            if (pick < 12)
                sig[0] = CHR_C;
            else if (pick < 22)
                sig[$urandom_range(0, 2)] = 8'($urandom);
            foreach (sig[i])
                fb.push_back(sig[i]);
            for (int i = 0; i < 5; i++)
                fb.push_back(8'($urandom));
            nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
            if ($urandom_range(0, 19) == 0)
                nbits = 31;
            fb.push_back({5'(nbits), 3'($urandom)});
            nskip = (4 * nbits + 4) / 8;
            for (int i = 0; i < nskip + 4; i++)
                fb.push_back(8'($urandom));
            ntags     = $urandom_range(1, 5);
            cut_short = 1'b0;
            for (int t = 0; t < ntags && !cut_short; t++)
            begin
                id   = ($urandom_range(0, 1) == 0) ? class_ids[$urandom_range(0, 6)]
                                                   : 10'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    lenv = (pick < 60) ? $urandom_range(0, 12) : $urandom_range(0, 62);
                    fb.push_back({id[1:0], lenv[5:0]});
                    fb.push_back(id[9:2]);
                end
                else
                begin
                    lenv = $urandom_range(0, 16);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        // huge length: only a few payload bytes before the next file
                        lenv      = $urandom;
                        cut_short = 1'b1;
                    end
                    fb.push_back({id[1:0], LEN_ESCAPE});
                    fb.push_back(id[9:2]);
                    for (int i = 0; i < 4; i++)
                        fb.push_back(lenv[8*i +: 8]);
                    if (cut_short)
                        lenv = $urandom_range(0, 4);
                end
                for (int i = 0; i < int'(lenv); i++)
                    fb.push_back(8'($urandom));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                cut = $urandom_range(1, fb.size());
                while (fb.size() > cut)
                    fb.delete(fb.size() - 1);
            end
            send_file(fb);
            sent += fb.size();
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // compare every output beat with the oldest expectation
    always @(posedge clk)
    begin
        fts_result_t got;
        fts_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind        = kind_t'(m_axis_tuser);
            got.data        = m_axis_tdata[7:0];
            got.tag_id      = m_axis_tdata[17:8];
            got.tag_class   = class_t'(m_axis_tdata[20:18]);
            got.tag_length  = m_axis_tdata[52:21];
            got.header_done = m_axis_tdata[53];
            got.fps_8p8     = m_axis_tdata[69:54];
            got.error_code  = err_t'(m_axis_tdata[71:70]);
            got.tag_last    = m_axis_tlast;
            if (pending_bytes.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected output beat, data %02h", got.data);
                fail_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (got !== want)
                begin
                    if (fail_count < 10)
                    begin
                        $display("mismatch exp: kind %0d data %02h id %0d cls %0d len %08h",
                                 want.kind, want.data, want.tag_id, want.tag_class,
                                 want.tag_length, " last %b done %b rate %04h err %0d",
                                 want.tag_last, want.header_done, want.fps_8p8,
                                 want.error_code);
                        $display("         got: kind %0d data %02h id %0d cls %0d len %08h",
                                 got.kind, got.data, got.tag_id, got.tag_class,
                                 got.tag_length, " last %b done %b rate %04h err %0d",
                                 got.tag_last, got.header_done, got.fps_8p8,
                                 got.error_code);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        fail_count     = 0;
        reset_parse_model();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_well_formed_file();
        test_signature_errors();
        test_random_phase(0, 0, 170);
        test_random_phase(88, 0, 170);
        test_random_phase(0, 88, 170);
        test_random_phase(13, 13, 170);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("flash_tag_stream_deframer_tb passed");
        else
            $display("flash_tag_stream_deframer_tb failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/fts_pkg.sv
sv/fts_parser.sv
sv/flash_tag_stream_deframer.sv
verif/flash_tag_stream_deframer_tb.sv
